@@ src/hcd_pkg.sv @@
// Shared types, constants and mod-26 helpers for the 3x3 Hill cipher decrypt block.
// No dependencies; imported by hcd_key_inv and hill_cipher_3x3_decrypt_top.
package hcd_pkg;

	localparam int unsigned KeyWidth = 45;
	localparam int unsigned LetterWidth = 5;
	localparam int unsigned ProdWidth = 10;
	localparam int unsigned SumWidth = 12;

	localparam logic [SumWidth-1:0] Alpha = 12'd26;
	// Offset that keeps a*b - c*d non-negative for 5-bit operands (26*37 >= 31*31).
	localparam logic [SumWidth-1:0] CrossBias = 12'd962;
	// floor(x/26) estimate: (x * 2520) >> 16 is floor or floor-1 for x < 4096.
	localparam logic [SumWidth-1:0] RecipMul = 12'd2520;
	localparam int unsigned RecipShift = 16;

	localparam logic [KeyWidth-1:0] KeyReset = 45'd17098617554694;
	// Busy-count reload after a key load, long enough for the inverse pipeline (s1..s6) to settle.
	localparam logic [2:0] SettleCycles = 3'd7;

	typedef struct packed {
		logic [LetterWidth-1:0] cipher_0;
		logic [LetterWidth-1:0] cipher_1;
		logic [LetterWidth-1:0] cipher_2;
	} in_word_t;

	typedef struct packed {
		logic [LetterWidth-1:0] plain_0;
		logic [LetterWidth-1:0] plain_1;
		logic [LetterWidth-1:0] plain_2;
		logic                   key_error;
	} out_word_t;

	typedef logic [LetterWidth-1:0] letter_t;

	// Key inverse and its status, handed from the inverse unit to the datapath.
	typedef struct packed {
		logic [8:0][LetterWidth-1:0] inv;       // row-major, zero when singular
		logic                        singular;
		logic                        busy;
	} key_inv_t;

	function automatic letter_t mod26(input logic [SumWidth-1:0] x);
		logic [2*SumWidth-1:0] p;
		logic [SumWidth-1:0]   q;
		logic [SumWidth-1:0]   r;
		p = x * RecipMul;
		q = {4'b0, p[RecipShift +: 8]};
		r = x - q * Alpha;
		if (r >= Alpha) begin
			r = r - Alpha;
		end
		return r[LetterWidth-1:0];
	endfunction

	// Multiplicative inverse mod 26; zero means no inverse exists.
	function automatic letter_t inv26(input letter_t d);
		letter_t r;
		case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

@@ src/hcd_key_inv.sv @@
// Key inverse unit: derives (det K)^-1 * adj(K) mod 26 from the key register.
// Depends on hcd_pkg; instantiated by hill_cipher_3x3_decrypt_top.
module hcd_key_inv import hcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [KeyWidth-1:0] key,
	input  logic                key_load,
	output key_inv_t            status
);

	letter_t k [3][3];

	logic [ProdWidth-1:0] pa_s1 [9];
	logic [ProdWidth-1:0] pb_s1 [9];
	letter_t              adj_s2 [9];
	logic [SumWidth-1:0]  detsum_s3;
	letter_t              dinv_s4;
	logic [ProdWidth-1:0] scaled_s5 [9];
	letter_t              inv_s6 [9];
	logic                 singular_s6;
	logic [2:0]           settle_q;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			k[i/3][i%3] = key[LetterWidth*i +: LetterWidth];
		end
	end

	// adjugate cross products, operands as in adj[r][c] = a*b - c*d
	always_ff @(posedge clk) begin
		pa_s1[0] <= k[1][1] * k[2][2];  pb_s1[0] <= k[1][2] * k[2][1];
		pa_s1[1] <= k[0][2] * k[2][1];  pb_s1[1] <= k[0][1] * k[2][2];
		pa_s1[2] <= k[0][1] * k[1][2];  pb_s1[2] <= k[0][2] * k[1][1];
		pa_s1[3] <= k[1][2] * k[2][0];  pb_s1[3] <= k[1][0] * k[2][2];
		pa_s1[4] <= k[0][0] * k[2][2];  pb_s1[4] <= k[0][2] * k[2][0];
		pa_s1[5] <= k[0][2] * k[1][0];  pb_s1[5] <= k[0][0] * k[1][2];
		pa_s1[6] <= k[1][0] * k[2][1];  pb_s1[6] <= k[1][1] * k[2][0];
		pa_s1[7] <= k[0][1] * k[2][0];  pb_s1[7] <= k[0][0] * k[2][1];
		pa_s1[8] <= k[0][0] * k[1][1];  pb_s1[8] <= k[0][1] * k[1][0];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			adj_s2[i] <= mod26({2'b0, pa_s1[i]} + CrossBias - {2'b0, pb_s1[i]});
		end
	end

	// det = first row of K dotted with first column of adj(K)
	always_ff @(posedge clk) begin
		detsum_s3 <= {2'b0, ProdWidth'(k[0][0] * adj_s2[0])}
			+ {2'b0, ProdWidth'(k[0][1] * adj_s2[3])}
			+ {2'b0, ProdWidth'(k[0][2] * adj_s2[6])};
	end

	always_ff @(posedge clk) begin
		dinv_s4 <= inv26(mod26(detsum_s3));
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			scaled_s5[i] <= adj_s2[i] * dinv_s4;
		end
	end

	// zero inverse when singular falls out of dinv == 0
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			inv_s6[i] <= mod26({2'b0, scaled_s5[i]});
		end
		singular_s6 <= (dinv_s4 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SettleCycles;
		end else if (key_load) begin
			settle_q <= SettleCycles;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			status.inv[i] = inv_s6[i];
		end
		status.singular = singular_s6;
		status.busy = (settle_q != '0);
	end

endmodule

@@ src/hill_cipher_3x3_decrypt_top.sv @@
// Top level of the 3x3 Hill cipher decrypt block: key register, item pipeline, output register.
// Depends on hcd_pkg and hcd_key_inv.
//
// Decrypts one three-letter Hill cipher block per word: plain = cipher * K^-1 mod 26.
// The 45-bit key (nine 5-bit entries, row-major, entry i at bits 5i) is written on the
// cfg channel; it resets to "gybnqkurp". After reset and after every key write the
// key inverse pipeline settles, and in_ready stays low meanwhile. After that the block
// takes one word per cycle while the output word is not held: the accepting edge loads
// the input register, the product register and the reduce-to-26 output register follow,
// and out_valid rises when the word reaches the output register. A key
// whose determinant has no inverse mod 26 gives key_error = 1 and all-zero letters.
// Letter codes 26..31 are treated as their value mod 26. Write the key only while idle.
module hill_cipher_3x3_decrypt_top import hcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [KeyWidth-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_word_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_word_t           out_data
);

	logic [KeyWidth-1:0]  key_q;
	logic                 cfg_fire;
	logic                 in_fire;
	logic                 advance;
	key_inv_t             kinv;

	letter_t              c_s1 [3];
	logic                 v_s1;
	logic [ProdWidth-1:0] prod_s2 [3][3];
	logic                 err_s2;
	logic                 v_s2;
	out_word_t            out_q;
	logic                 out_valid_q;
	letter_t              plain [3];

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KeyReset;
		end else if (cfg_fire) begin
			key_q <= cfg_data;
		end
	end

	hcd_key_inv u_key_inv (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.key_load (cfg_fire),
		.status   (kinv)
	);

	// whole pipe moves together; it only halts when the output word is held
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance && !kinv.busy;
	assign in_fire  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= in_fire;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (advance) begin
			c_s1[0] <= in_data.cipher_0;
			c_s1[1] <= in_data.cipher_1;
			c_s1[2] <= in_data.cipher_2;
		end
	end

	// stage 2: the nine letter * inverse-entry products
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= c_s1[i] * kinv.inv[3*i+j];
				end
			end
			err_s2 <= kinv.singular;
		end
	end

	// column sums reduced mod 26 (max 3*31*25, fits 12 bits)
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			plain[j] = mod26({2'b0, prod_s2[0][j]} + {2'b0, prod_s2[1][j]}
				+ {2'b0, prod_s2[2][j]});
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.plain_0   <= plain[0];
			out_q.plain_1   <= plain[1];
			out_q.plain_2   <= plain[2];
			out_q.key_error <= err_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// singular key must never leak letters
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.key_error |->
			out_data.plain_0 == '0 && out_data.plain_1 == '0 && out_data.plain_2 == '0)
		else $error("key_error word carries nonzero letters");

	// a key write must close the input until the inverse has settled
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> !in_ready)
		else $error("input open right after key write");

	// no word enters while the inverse is still being derived
	a_no_busy_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !kinv.busy)
		else $error("word accepted during key inverse settle");

	// a held output word keeps the pipe frozen behind it
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_q) && $stable(v_s2))
		else $error("pipeline moved while output stalled");

endmodule

@@ bench/hill_cipher_3x3_decrypt_checker.sv @@
// Checker for the 3x3 Hill cipher decrypt block: tracks the key, predicts each word, compares.
// Depends on hcd_pkg for the word types, widths and the reset key.
module hill_cipher_3x3_decrypt_checker import hcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [KeyWidth-1:0] cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  in_word_t            in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  out_word_t           out_data,
	output int                  fail_count,
	output int                  pending
);

	localparam int Letters   = 26;
	localparam int ReportMax = 10;

	logic [KeyWidth-1:0] key_shadow;
	out_word_t           expected_plain_q[$];
	int                  errors;

	// (a*b - c*d) mod 26, operands already in 0..25
	function automatic int cross26(input int a, input int b, input int c, input int d);
		return (a * b - c * d + Letters * Letters) % Letters;
	endfunction

	// plain = cipher * K^-1 mod 26; zeros and the error flag for a singular key
	function automatic out_word_t decrypt_block(input logic [KeyWidth-1:0] key,
	                                            input in_word_t w);
		int        k[3][3];
		int        adj[3][3];
		int        c[3];
		int        p[3];
		int        det;
		int        det_inv;
		int        i;
		int        j;
		out_word_t r;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				k[i][j] = int'(key[5 * (3 * i + j) +: 5]) % Letters;
			end
		end
		adj[0][0] = cross26(k[1][1], k[2][2], k[1][2], k[2][1]);
		adj[0][1] = cross26(k[0][2], k[2][1], k[0][1], k[2][2]);
		adj[0][2] = cross26(k[0][1], k[1][2], k[0][2], k[1][1]);
		adj[1][0] = cross26(k[1][2], k[2][0], k[1][0], k[2][2]);
		adj[1][1] = cross26(k[0][0], k[2][2], k[0][2], k[2][0]);
		adj[1][2] = cross26(k[0][2], k[1][0], k[0][0], k[1][2]);
		adj[2][0] = cross26(k[1][0], k[2][1], k[1][1], k[2][0]);
		adj[2][1] = cross26(k[0][1], k[2][0], k[0][0], k[2][1]);
		adj[2][2] = cross26(k[0][0], k[1][1], k[0][1], k[1][0]);
		det = (k[0][0] * adj[0][0] + k[0][1] * adj[1][0] + k[0][2] * adj[2][0]) % Letters;

		det_inv = 0;
		for (i = 1; i < Letters && det_inv == 0; i++) begin
			if ((det * i) % Letters == 1) det_inv = i;
		end

		r = '0;
		if (det_inv == 0) begin
			r.key_error = 1'b1;
			return r;
		end

		c[0] = int'(w.cipher_0) % Letters;
		c[1] = int'(w.cipher_1) % Letters;
		c[2] = int'(w.cipher_2) % Letters;
		for (j = 0; j < 3; j++) begin
			p[j] = 0;
			for (i = 0; i < 3; i++) begin
				p[j] = (p[j] + c[i] * ((adj[i][j] * det_inv) % Letters)) % Letters;
			end
		end
		r.plain_0 = letter_t'(p[0]);
		r.plain_1 = letter_t'(p[1]);
		r.plain_2 = letter_t'(p[2]);
		return r;
	endfunction

	// out first, so a word leaving at the same edge never matches one just taken in
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			key_shadow = KeyReset;
			expected_plain_q.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_plain_q.size() == 0) begin
					if (errors < ReportMax)
						$display("%0t: unexpected word p=%0d,%0d,%0d err=%0b", $realtime,
						         out_data.plain_0, out_data.plain_1, out_data.plain_2,
						         out_data.key_error);
					errors++;
				end else begin
					want = expected_plain_q.pop_front();
					if (out_data.plain_0 !== want.plain_0 || out_data.plain_1 !== want.plain_1 ||
					    out_data.plain_2 !== want.plain_2 ||
					    out_data.key_error !== want.key_error) begin
						if (errors < ReportMax)
							$display("%0t: mismatch exp p=%0d,%0d,%0d err=%0b got p=%0d,%0d,%0d err=%0b",
							         $realtime, want.plain_0, want.plain_1, want.plain_2,
							         want.key_error, out_data.plain_0, out_data.plain_1,
							         out_data.plain_2, out_data.key_error);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) key_shadow = cfg_data;
			if (in_valid && in_ready)
				expected_plain_q = {expected_plain_q, decrypt_block(key_shadow, in_data)};
			fail_count <= errors;
			pending <= expected_plain_q.size();
		end
	end

endmodule

@@ bench/hill_cipher_3x3_decrypt_top_tb.sv @@
// Testbench top for the 3x3 Hill cipher decrypt block: clock, reset, stimulus and verdict.
// Depends on hcd_pkg, hill_cipher_3x3_decrypt_top and hill_cipher_3x3_decrypt_checker.
module hill_cipher_3x3_decrypt_top_tb;
	import hcd_pkg::*;

	localparam int QuietLimit    = 2000; // cycles with no handshake on any channel
	localparam int TailCycles    = 20;   // pipeline is three deep; plenty of margin
	localparam int RandomPhases  = 12;
	localparam int WordsPerPhase = 125;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [KeyWidth-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_word_t            in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_word_t           out_data;

	int fail_count;
	int pending;
	int idle_pct     = 0;  // chance per word that the sender idles before it
	int stall_pct    = 0;  // chance per cycle that the receiver holds off
	int quiet_cycles = 0;

	hill_cipher_3x3_decrypt_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	hill_cipher_3x3_decrypt_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: a fresh coin every cycle, so stalls land on every phase of the pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog: any accepted word on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("[hill_cipher_3x3_decrypt_top] ERROR");
			$finish;
		end
	end

	// Key determinant invertible mod 26: odd and not a multiple of 13.
	// Raw 5-bit entries are fine here since the determinant is a polynomial.
	function automatic bit key_invertible(input logic [KeyWidth-1:0] key);
		int e[9];
		int d;
		int i;
		for (i = 0; i < 9; i++) begin
			e[i] = int'(key[5 * i +: 5]);
		end
		d = e[0] * (e[4] * e[8] - e[5] * e[7]) - e[1] * (e[3] * e[8] - e[5] * e[6])
		  + e[2] * (e[3] * e[7] - e[4] * e[6]);
		d = ((d % 26) + 26) % 26;
		return (d % 2 == 1) && (d % 13 != 0);
	endfunction

	// Full 45-bit random key; entries 26..31 come up on their own.
	function automatic logic [KeyWidth-1:0] rand_key(input bit invertible_only);
		logic [63:0] raw;
		do begin
			raw = {$urandom(), $urandom()};
		end while (invertible_only && !key_invertible(raw[KeyWidth-1:0]));
		return raw[KeyWidth-1:0];
	endfunction

	// Mostly real letters, one in five over the whole 5-bit range.
	function automatic letter_t rand_letter();
		if ($urandom_range(0, 4) == 0) return letter_t'($urandom_range(0, 31));
		return letter_t'($urandom_range(0, 25));
	endfunction

	task automatic set_pressure(input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
	endtask

	// Leaves valid high after acceptance; it only drops when a gap is drawn,
	// so back-to-back words never see a low/high pair in one step.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_letters(input int a, input int b, input int c);
		in_word_t w;
		w.cipher_0 = letter_t'(a);
		w.cipher_1 = letter_t'(b);
		w.cipher_2 = letter_t'(c);
		send_word(w);
	endtask

	// Key is only changed once the pipeline has drained. The first wait edge
	// already sees the word taken at the edge the last send returned on.
	task automatic load_key(input logic [KeyWidth-1:0] key);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		cfg_valid <= 1'b1;
		cfg_data <= key;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                  p;
		int                  n;
		int                  i;
		logic [KeyWidth-1:0] key;
		in_word_t            w;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset key: letter extremes, one-hot rows, codes 26..31 on input.
		send_letters(0, 0, 0);
		send_letters(25, 25, 25);
		send_letters(31, 31, 31);
		send_letters(26, 27, 28);
		send_letters(29, 30, 31);
		send_letters(25, 0, 0);
		send_letters(0, 25, 0);
		send_letters(0, 0, 25);
		send_letters(1, 0, 0);
		send_letters(0, 1, 0);
		send_letters(0, 0, 1);
		send_letters(19, 4, 7);

		// Singular keys: all zero, all 31 (rank one), det 13 and det 2.
		load_key('0);
		send_letters(0, 0, 0);
		send_letters(25, 13, 31);
		load_key({KeyWidth{1'b1}});
		send_letters(31, 31, 31);
		send_letters(7, 8, 9);
		load_key(KeyWidth'(13) | (KeyWidth'(1) << 20) | (KeyWidth'(1) << 40));
		send_letters(12, 5, 20);
		send_letters(25, 25, 25);
		load_key(KeyWidth'(2) | (KeyWidth'(1) << 20) | (KeyWidth'(1) << 40));
		send_letters(3, 17, 9);

		// Identity written with codes 27 on the diagonal and 26 elsewhere.
		key = '0;
		for (i = 0; i < 9; i++) begin
			key[5 * i +: 5] = (i % 4 == 0) ? 5'd27 : 5'd26;
		end
		load_key(key);
		send_letters(31, 26, 3);
		send_letters(0, 30, 25);
		send_letters(14, 2, 29);

		// Random phases: mostly invertible keys so the datapath is exercised,
		// every third one any key at all. Pressure rotates through four modes.
		for (p = 0; p < RandomPhases; p++) begin
			load_key(rand_key(p % 3 != 2));
			case (p % 4)
				0: set_pressure(0, 0);
				1: set_pressure(53, 0);
				2: set_pressure(0, 53);
				default: set_pressure(23, 23);
			endcase
			for (n = 0; n < WordsPerPhase; n++) begin
				w.cipher_0 = rand_letter();
				w.cipher_1 = rand_letter();
				w.cipher_2 = rand_letter();
				send_word(w);
			end
		end

		// Drain, then a quiet tail to catch any stray word.
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[hill_cipher_3x3_decrypt_top] OK");
		end else begin
			$display("[hill_cipher_3x3_decrypt_top] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/hcd_pkg.sv
src/hcd_key_inv.sv
src/hill_cipher_3x3_decrypt_top.sv
bench/hill_cipher_3x3_decrypt_checker.sv
bench/hill_cipher_3x3_decrypt_top_tb.sv
